FILE: src/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    // input word kinds (s_axis_tuser)
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // selection rules; the unused code behaves as first fit
    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    // configuration register indexes
    localparam logic REG_FIT_POLICY    = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    localparam int CFG_DATA_W       = 4;
    localparam int IDX_FIELD_W      = 3;
    localparam int SIZE_FIELD_W     = 16;
    localparam int DATA_W           = 24;
    localparam logic [3:0] BLOCKS_RESET = 4'd8;

    typedef struct packed {
        logic load_write;  // write a loaded free size
        logic scan_start;  // latch request, clear search state
        logic scan_issue;  // read next entry
        logic write_back;  // store reduced size of chosen entry
        logic out_load;    // capture result word
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;   // entry being read is the last searched one
        logic limit_zero;  // nothing to search
        logic out_free;    // result register can take a word
    } dp_status_t;

endpackage

FILE: src/fit_policy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// Block allocator with first, best and worst fit over a table of free sizes.
// ----------------------------------------------------------------------------
// A load word (tuser 0) writes one table entry and gives no result. An
// allocate word (tuser 1) scans entries 0 to min(blocks_in_use, NUM_BLOCKS)-1
// with one comparator that reads the table one entry per cycle through the
// table's single read port; no new word is accepted until the scan is done
// and its result is loaded into the output register. The result word sits in
// an output register and the next word is accepted while it waits. Table
// entries have no reset and must be loaded before they are searched.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,  // block_index[2:0], size_value[18:3]
    input  logic                  s_axis_tuser,  // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,  // chosen_block[2:0], left_after[18:3]
    output logic                  m_axis_tuser,  // granted
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);

    logic [1:0]              fit_policy_reg;
    logic [3:0]              blocks_in_use_reg;
    logic [CNT_W-1:0]        limit;
    dp_cmd_t                 cmd;
    dp_status_t              status;
    logic [IDX_FIELD_W-1:0]  chosen_block;
    logic [SIZE_FIELD_W-1:0] left_after;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg    <= POLICY_FIRST;
            blocks_in_use_reg <= BLOCKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FIT_POLICY:    fit_policy_reg    <= cfg_data[1:0];
                REG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // saturate the search length to the table depth
    always_comb
    begin
        if (32'(blocks_in_use_reg) > NUM_BLOCKS)
        begin
            limit = CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            limit = CNT_W'(blocks_in_use_reg);
        end
    end

    fpba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fpba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .fit_policy   (fit_policy_reg),
        .limit        (limit),
        .block_index  (s_axis_tdata[2:0]),
        .size_value   (s_axis_tdata[18:3]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .granted      (m_axis_tuser),
        .chosen_block (chosen_block),
        .left_after   (left_after)
    );

    assign m_axis_tdata = {5'd0, left_after, chosen_block};

endmodule

FILE: src/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: accepts words, steps the table scan, hands off results.
// ----------------------------------------------------------------------------
module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_cmd,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_ALLOC)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = status.limit_zero ? ST_FINISH : ST_SCAN;
                    end
                    else
                    begin
                        cmd.load_write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                // last read entry is compared here
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // write-back may repeat while waiting; same value each time
                cmd.write_back = 1'b1;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_alloc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_cmd == CMD_ALLOC) |=> state_reg != ST_IDLE)
        else $error("allocate accepted but sequencer stayed idle");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_cmd == CMD_LOAD) |=> state_reg == ST_IDLE)
        else $error("load word left the idle state");

endmodule

FILE: src/fpba_datapath.sv
// ----------------------------------------------------------------------------
// fpba_datapath
// Free-size table, single comparator scan, write-back and result register.
// ----------------------------------------------------------------------------
module fpba_datapath
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = 8,
    parameter int SIZE_BITS  = 16,
    parameter int ADDR_W     = 3,
    parameter int CNT_W      = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic [1:0]              fit_policy,
    input  logic [CNT_W-1:0]        limit,
    input  logic [IDX_FIELD_W-1:0]  block_index,
    input  logic [SIZE_FIELD_W-1:0] size_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    granted,
    output logic [IDX_FIELD_W-1:0]  chosen_block,
    output logic [SIZE_FIELD_W-1:0] left_after
);

    logic [SIZE_BITS-1:0]    mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0]    rd_data_reg;
    logic [ADDR_W-1:0]       scan_addr_reg;
    logic [ADDR_W-1:0]       cmp_idx_reg;
    logic                    cmp_valid_reg;
    logic [SIZE_BITS-1:0]    req_reg;
    logic                    found_reg;
    logic [ADDR_W-1:0]       best_idx_reg;
    logic [SIZE_BITS-1:0]    best_val_reg;
    logic                    out_valid_reg;
    logic                    out_granted_reg;
    logic [IDX_FIELD_W-1:0]  out_block_reg;
    logic [SIZE_FIELD_W-1:0] out_left_reg;

    logic                    load_in_range;
    logic [ADDR_W-1:0]       load_addr;
    logic                    fits;
    logic                    take;
    logic [SIZE_BITS-1:0]    remain;

    assign load_in_range = (32'(block_index) < NUM_BLOCKS);
    assign load_addr     = ADDR_W'(32'(block_index));
    assign remain        = best_val_reg - req_reg;

    assign status.scan_last  = ((CNT_W'(scan_addr_reg) + CNT_W'(1)) == limit);
    assign status.limit_zero = (limit == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    // candidate selection on the word read last cycle
    always_comb
    begin
        fits = cmp_valid_reg && (rd_data_reg >= req_reg);
        take = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else
            begin
                case (fit_policy)
                    POLICY_BEST:  take = (rd_data_reg < best_val_reg);
                    POLICY_WORST: take = (rd_data_reg > best_val_reg);
                    default:      take = 1'b0;
                endcase
            end
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_write && load_in_range)
        begin
            mem[load_addr] <= SIZE_BITS'(size_value);
        end
        else if (cmd.write_back && found_reg)
        begin
            mem[best_idx_reg] <= remain;
        end
        rd_data_reg <= mem[scan_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_addr_reg;
        if (cmd.scan_start)
        begin
            req_reg <= SIZE_BITS'(size_value);
        end
        if (take)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_val_reg <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            out_granted_reg <= found_reg;
            out_block_reg   <= found_reg ? IDX_FIELD_W'(best_idx_reg) : '0;
            out_left_reg    <= found_reg ? SIZE_FIELD_W'(remain) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_issue;
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    scan_addr_reg <= scan_addr_reg + ADDR_W'(1);
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = out_granted_reg;
    assign chosen_block = out_block_reg;
    assign left_after   = out_left_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !out_valid_reg || out_ready)
        else $error("result register overwritten while still pending");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_write && cmd.write_back))
        else $error("load and write-back in the same cycle");

    a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && found_reg |-> best_val_reg >= req_reg)
        else $error("granted block smaller than request");

endmodule
